// File: hdl/smf_pkg.sv
package smf_pkg;

  // configuration register indexes (byte address is 4 * index)
  localparam logic [1:0] REG_WINDOW_SIZE = 2'd0;
  localparam logic [1:0] REG_SKIP_FRONT  = 2'd1;
  localparam logic [1:0] REG_KEEP_COUNT  = 2'd2;

  // fixed register widths
  localparam int unsigned WSIZE_BITS = 4;
  localparam int unsigned RANGE_BITS = 16;
  localparam int unsigned ADDR_BITS  = 4;
  localparam int unsigned DATA_BITS  = 32;

  // register reset values
  localparam logic [WSIZE_BITS-1:0] WSIZE_RESET = 4'd5;
  localparam logic [RANGE_BITS-1:0] SKIP_RESET  = 16'd0;
  localparam logic [RANGE_BITS-1:0] KEEP_RESET  = 16'hFFFF;

  // control sent from the sequencer to every cell of the chain
  typedef struct packed {
    logic shift;
    logic fill;
  } cell_ctrl_t;

endpackage

// File: hdl/smf_in_if.sv
interface smf_in_if #(
  parameter int unsigned SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

// File: hdl/smf_out_if.sv
interface smf_out_if #(
  parameter int unsigned SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] median;
  logic                   run_last;
  logic                   record_end;

  modport source (output valid, output median, output run_last, output record_end,
                  input ready);
  modport sink   (input valid, input median, input run_last, input record_end,
                  output ready);
endinterface

// File: hdl/smf_cell.sv
module smf_cell #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned MAX_WINDOW  = 15,
  parameter int unsigned INDEX       = 0,
  parameter int unsigned WIN_W       = 4
) (
  input  logic                                    clk_i,
  input  smf_pkg::cell_ctrl_t                     ctrl_i,
  input  logic [SAMPLE_BITS-1:0]                  fill_i,
  input  logic [SAMPLE_BITS-1:0]                  prev_i,
  input  logic [MAX_WINDOW-1:0][SAMPLE_BITS-1:0]  win_i,
  input  logic [MAX_WINDOW-1:0]                   active_i,
  input  logic [WIN_W-1:0]                        rank_sel_i,
  output logic [SAMPLE_BITS-1:0]                  value_o,
  output logic                                    hit_o
);
  import smf_pkg::*;

  logic [SAMPLE_BITS-1:0] value_q, value_d;
  logic [MAX_WINDOW-1:0]  below;
  logic [WIN_W-1:0]       rank;

  // load from the neighbour on a shift, from the broadcast value on a fill
  always_comb begin
    value_d = value_q;
    if (ctrl_i.fill) begin
      value_d = fill_i;
    end else if (ctrl_i.shift) begin
      value_d = prev_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  // rank among active cells, ties broken by position so ranks are distinct
  always_comb begin
    for (int j = 0; j < MAX_WINDOW; j++) begin
      below[j] = active_i[j] && (j != INDEX) &&
                 ((win_i[j] < value_q) || ((win_i[j] == value_q) && (j < INDEX)));
    end
  end

  assign rank    = WIN_W'($countones(below));
  assign hit_o   = active_i[INDEX] && (rank == rank_sel_i);
  assign value_o = value_q;

endmodule

// File: hdl/sliding_median_filter_core.sv
// channel   dir  payload                         request taken when
// in_i      in   sample, last                    in_i.valid && in_i.ready
// out_o     out  median, run_last, record_end    out_o.valid && out_o.ready
// apb       in   window_size, skip_front, keep   psel && penable && pwrite
//
// a request is taken only when the sequencer is idle; the next cycle starts
// the median steps. an ordinary sample closes with a single step; a sample
// flagged last takes window_size - 1 - window_size/2 more steps that each
// shift the cell chain, one shift per cycle, but a step that emits waits while
// the output register is full and not taken. rst_ni clears control state only;
// the cells are loaded with each record's first sample and need no clearing.
module sliding_median_filter_core #(
  parameter int unsigned MAX_WINDOW  = 15,
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [smf_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [smf_pkg::DATA_BITS-1:0]   pwdata,
  output logic [smf_pkg::DATA_BITS-1:0]   prdata,
  output logic                            pready,
  smf_in_if.sink                          in_i,
  smf_out_if.source                       out_o
);
  import smf_pkg::*;

  localparam int unsigned WIN_W = (MAX_WINDOW < 2) ? 1 : $clog2(MAX_WINDOW + 1);
  localparam int unsigned EW    = (WIN_W > WSIZE_BITS) ? WIN_W : WSIZE_BITS;
  localparam int unsigned CW    = ((COUNT_BITS > RANGE_BITS) ? COUNT_BITS : RANGE_BITS) + 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  // configuration registers
  logic [WSIZE_BITS-1:0] wsize_q;
  logic [RANGE_BITS-1:0] skip_q, keep_q;
  logic                  cfg_wr;

  // sequencer and record state
  logic                   state_q, state_d;
  logic [SAMPLE_BITS-1:0] sample_q, sample_d;
  logic                   last_q, last_d;
  logic [WIN_W-1:0]       k_q, k_d;
  logic [COUNT_BITS-1:0]  sc_q, sc_d, pos_q, pos_d;
  logic                   started_q, started_d;

  // output register
  logic                   ovalid_q, ovalid_d;
  logic [SAMPLE_BITS-1:0] omed_q, omed_d;
  logic                   orun_q, orun_d, oend_q, oend_d;

  // window geometry
  logic [EW-1:0]          ws_ext, w_ext;
  logic [WIN_W-1:0]       w_eff, half, look;
  logic [MAX_WINDOW-1:0]  active;

  // step decisions
  logic                   accept, step, fin, more, emit_cur, emit_nx, out_free, load;
  logic [WIN_W-1:0]       end_k;
  logic [COUNT_BITS-1:0]  pos_nx;

  // cell chain
  cell_ctrl_t                             ctrl;
  logic [SAMPLE_BITS-1:0]                 shift_val;
  logic [MAX_WINDOW-1:0][SAMPLE_BITS-1:0] win;
  logic [MAX_WINDOW-1:0]                  hit;
  logic [SAMPLE_BITS-1:0]                 median;

  function automatic logic in_range(input logic [COUNT_BITS-1:0] p,
                                    input logic [RANGE_BITS-1:0] s,
                                    input logic [RANGE_BITS-1:0] n);
    logic [CW-1:0] pe, se, ne;
    pe = CW'(p);
    se = CW'(s);
    ne = CW'(n);
    return (pe >= se) && ((pe - se) < ne);
  endfunction

  // apb register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsize_q <= WSIZE_RESET;
      skip_q  <= SKIP_RESET;
      keep_q  <= KEEP_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_WINDOW_SIZE: wsize_q <= pwdata[WSIZE_BITS-1:0];
        REG_SKIP_FRONT:  skip_q  <= pwdata[RANGE_BITS-1:0];
        REG_KEEP_COUNT:  keep_q  <= pwdata[RANGE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WINDOW_SIZE: prdata = DATA_BITS'(wsize_q);
      REG_SKIP_FRONT:  prdata = DATA_BITS'(skip_q);
      REG_KEEP_COUNT:  prdata = DATA_BITS'(keep_q);
      default:         prdata = '0;
    endcase
  end

  // effective window, median rank and look-ahead
  assign ws_ext = EW'(wsize_q);
  always_comb begin
    if (wsize_q == '0) begin
      w_ext = EW'(1);
    end else if (ws_ext > EW'(MAX_WINDOW)) begin
      w_ext = EW'(MAX_WINDOW);
    end else begin
      w_ext = ws_ext;
    end
  end
  assign w_eff = w_ext[WIN_W-1:0];
  assign half  = w_eff >> 1;
  assign look  = w_eff - WIN_W'(1) - half;

  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      active[i] = (WIN_W'(i) < w_eff);
    end
  end

  // step decisions
  assign accept   = in_i.valid && in_i.ready;
  assign end_k    = last_q ? look : '0;
  assign more     = (k_q != end_k);
  assign fin      = (sc_q > COUNT_BITS'(look - k_q));
  assign pos_nx   = (pos_q == CNT_MAX) ? pos_q : pos_q + COUNT_BITS'(1);
  assign emit_cur = in_range(pos_q, skip_q, keep_q);
  assign emit_nx  = in_range(pos_nx, skip_q, keep_q);
  assign out_free = !ovalid_q || out_o.ready;
  assign step     = (state_q == ST_RUN) && (!(fin && emit_cur) || out_free);
  assign load     = step && fin && emit_cur;

  assign in_i.ready = (state_q == ST_IDLE);

  // sequencer next state
  always_comb begin
    state_d   = state_q;
    sample_d  = sample_q;
    last_d    = last_q;
    k_d       = k_q;
    sc_d      = sc_q;
    pos_d     = pos_q;
    started_d = started_q;
    if (accept) begin
      state_d   = ST_RUN;
      sample_d  = in_i.sample;
      last_d    = in_i.last;
      k_d       = '0;
      sc_d      = (sc_q == CNT_MAX) ? sc_q : sc_q + COUNT_BITS'(1);
      started_d = 1'b1;
    end else if (step) begin
      if (fin) begin
        pos_d = pos_nx;
      end
      if (more) begin
        k_d = k_q + WIN_W'(1);
      end else begin
        state_d = ST_IDLE;
        if (last_q) begin
          sc_d      = '0;
          pos_d     = '0;
          started_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      last_q    <= 1'b0;
      k_q       <= '0;
      sc_q      <= '0;
      pos_q     <= '0;
      started_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      last_q    <= last_d;
      k_q       <= k_d;
      sc_q      <= sc_d;
      pos_q     <= pos_d;
      started_q <= started_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
  end

  // cell chain control
  assign shift_val  = (state_q == ST_IDLE) ? in_i.sample : sample_q;
  assign ctrl.fill  = accept && !started_q;
  assign ctrl.shift = (accept && started_q) || (step && more);

  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
    logic [SAMPLE_BITS-1:0] prev;
    if (g == 0) begin : g_head
      assign prev = shift_val;
    end else begin : g_body
      assign prev = win[g-1];
    end
    smf_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_WINDOW  (MAX_WINDOW),
      .INDEX       (g),
      .WIN_W       (WIN_W)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .fill_i     (shift_val),
      .prev_i     (prev),
      .win_i      (win),
      .active_i   (active),
      .rank_sel_i (half),
      .value_o    (win[g]),
      .hit_o      (hit[g])
    );
  end

  // pick the single cell whose rank is the median rank
  always_comb begin
    median = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      median = median | (hit[i] ? win[i] : '0);
    end
  end

  // output register
  always_comb begin
    ovalid_d = ovalid_q && !out_o.ready;
    omed_d   = omed_q;
    orun_d   = orun_q;
    oend_d   = oend_q;
    if (load) begin
      ovalid_d = 1'b1;
      omed_d   = median;
      orun_d   = !(more && emit_nx);
      oend_d   = last_q && !(more && emit_nx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    omed_q <= omed_d;
    orun_q <= orun_d;
    oend_q <= oend_d;
  end

  assign out_o.valid      = ovalid_q;
  assign out_o.median     = omed_q;
  assign out_o.run_last   = orun_q;
  assign out_o.record_end = oend_q;

  // record end only ever marks the closing result of a request
  a_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && oend_q) |-> orun_q)
    else $error("record_end without run_last");

  // exactly one cell holds the median rank while steps run
  a_one_median: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> $onehot(hit))
    else $error("median rank not unique");

  // closing a record returns the counters to their reset values
  a_record_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && !more && last_q) |=> (sc_q == '0) && (pos_q == '0) && !started_q)
    else $error("record state not cleared");

endmodule

// File: dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import smf_pkg::*;

  localparam int unsigned MAX_WIN      = 15;
  localparam int unsigned COUNT_MAX    = 65535;
  localparam int unsigned SETTLE_CYC   = 24;
  localparam int unsigned QUIET_LIMIT  = 3000;
  localparam int unsigned RANDOM_ITEMS = 300;

  typedef struct packed {
    logic [11:0] median;
    logic        run_last;
    logic        record_end;
  } median_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  reg_idx;
    logic [31:0] value;
    logic [11:0] sample;
    logic        last;
    logic        typed;
    logic        typed_n;
    median_t     typed_res;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  smf_in_if  #(.SAMPLE_BITS(12)) in_ch ();
  smf_out_if #(.SAMPLE_BITS(12)) out_ch ();

  sliding_median_filter_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_ch),
    .out_o   (out_ch)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state and register copies
  logic [3:0]  cfg_wsize = WSIZE_RESET;
  logic [15:0] cfg_skip  = SKIP_RESET;
  logic [15:0] cfg_keep  = KEEP_RESET;
  logic [11:0] window_hist [MAX_WIN];
  int unsigned samples_seen  = 0;
  int unsigned next_position = 0;
  bit          record_open   = 1'b0;

  median_t     step_results [$];
  median_t     pending_medians [$];
  int unsigned errors = 0;
  bit          src_burst = 1'b0;
  bit          snk_burst = 1'b0;

  task automatic report(input string msg);
    if (errors < 50) $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // newest sample enters at index 0, oldest falls off the end
  function automatic void shift_hist(logic [11:0] s);
    for (int i = MAX_WIN - 1; i > 0; i--) window_hist[i] = window_hist[i-1];
    window_hist[0] = s;
  endfunction

  // median of the newest w samples, upper middle for even sizes
  function automatic logic [11:0] window_median(int unsigned w);
    logic [11:0] srt [MAX_WIN];
    logic [11:0] v;
    int          j;
    for (int i = 0; i < w; i++) begin
      v = window_hist[i];
      j = i;
      while (j > 0 && srt[j-1] > v) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = v;
    end
    return srt[w / 2];
  endfunction

  // finish the position under the counter and keep it if in the emitted range
  function automatic void close_position(int unsigned w);
    median_t     r;
    int unsigned p;
    p = next_position;
    r.median     = window_median(w);
    r.run_last   = 1'b0;
    r.record_end = 1'b0;
    if (next_position < COUNT_MAX) next_position++;
    if (p >= cfg_skip && (p - cfg_skip) < cfg_keep) step_results.push_back(r);
  endfunction

  // medians caused by one accepted request, left in step_results
  function automatic void predict_medians(logic [11:0] s, logic lst);
    int unsigned w;
    int unsigned la;
    step_results.delete();
    w  = (cfg_wsize == 0) ? 1 : ((cfg_wsize > MAX_WIN) ? MAX_WIN : cfg_wsize);
    la = w - 1 - w / 2;
    if (!record_open) begin
      for (int i = 0; i < MAX_WIN; i++) window_hist[i] = s;
      record_open = 1'b1;
    end else begin
      shift_hist(s);
    end
    if (samples_seen < COUNT_MAX) samples_seen++;
    if (samples_seen > la) close_position(w);
    if (lst) begin
      // flush with copies of the final sample
      for (int unsigned k = 1; k <= la; k++) begin
        shift_hist(s);
        if (samples_seen + k > la) close_position(w);
      end
      if (step_results.size() > 0) step_results[$].record_end = 1'b1;
      for (int i = 0; i < MAX_WIN; i++) window_hist[i] = '0;
      samples_seen  = 0;
      next_position = 0;
      record_open   = 1'b0;
    end
    if (step_results.size() > 0) step_results[$].run_last = 1'b1;
  endfunction

  // result checker
  always @(posedge clk_i) begin : check_results
    median_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_medians.size() == 0) begin
        report($sformatf("median %0h arrived with nothing expected", out_ch.median));
      end else begin
        want = pending_medians.pop_front();
        if (out_ch.median !== want.median)
          report($sformatf("median %0h, expected %0h", out_ch.median, want.median));
        if (out_ch.run_last !== want.run_last)
          report($sformatf("run_last %b, expected %b", out_ch.run_last, want.run_last));
        if (out_ch.record_end !== want.record_end)
          report($sformatf("record_end %b, expected %b", out_ch.record_end,
                           want.record_end));
      end
    end
  end

  // watchdog on cycles with no request taken anywhere
  always @(posedge clk_i) begin : watchdog
    int unsigned quiet;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("timeout: no progress for %0d cycles", QUIET_LIMIT);
      $display("sliding_median_filter_core verification failed");
      $finish;
    end
  end

  // result side: ready either held high or raised after a stall on valid
  initial begin : result_sink
    int unsigned stall;
    out_ch.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (snk_burst || $urandom_range(0, 1) == 1) begin
        out_ch.ready <= 1'b1;
        do @(posedge clk_i); while (!out_ch.valid);
      end else begin
        out_ch.ready <= 1'b0;
        do @(posedge clk_i); while (!out_ch.valid);
        stall = $urandom_range(0, 10);
        repeat (stall) @(posedge clk_i);
        out_ch.ready <= 1'b1;
        do @(posedge clk_i); while (!out_ch.valid);
      end
    end
  end

  // one sample request; typed rows replace the predicted results
  task automatic send_sample(input logic [11:0] s, input logic lst, input bit typed,
                             input bit typed_n, input median_t typed_res);
    int unsigned gap;
    gap = src_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    in_ch.last   <= lst;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_medians(s, lst);
    if (typed) begin
      if (typed_n) pending_medians.push_back(typed_res);
    end else begin
      foreach (step_results[i]) pending_medians.push_back(step_results[i]);
    end
  endtask

  // drop valid, drain expected results, then let the sequencer go quiet
  task automatic wait_settled();
    in_ch.valid <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // register write with read-back, only once the block is idle
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] rd;
    logic [31:0] want;
    wait_settled();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    unique case (idx)
      REG_WINDOW_SIZE: cfg_wsize = val[3:0];
      REG_SKIP_FRONT:  cfg_skip  = val[15:0];
      REG_KEEP_COUNT:  cfg_keep  = val[15:0];
      default: ;
    endcase
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    want = (idx == REG_WINDOW_SIZE) ? {28'd0, val[3:0]} : {16'd0, val[15:0]};
    if (rd !== want) report($sformatf("register %0d reads %0h, expected %0h", idx, rd, want));
  endtask

  function automatic stim_row_t wr_row(logic [1:0] idx, logic [31:0] val);
    stim_row_t r;
    r = '0;
    r.kind    = ROW_WRITE;
    r.reg_idx = idx;
    r.value   = val;
    return r;
  endfunction

  function automatic stim_row_t smp_row(logic [11:0] s, logic lst);
    stim_row_t r;
    r = '0;
    r.kind   = ROW_SAMPLE;
    r.sample = s;
    r.last   = lst;
    return r;
  endfunction

  // sample row with its outcome written out: none, or one median
  function automatic stim_row_t typed_row(logic [11:0] s, logic lst, logic n,
                                          logic [11:0] med, logic rl, logic re);
    stim_row_t r;
    r = smp_row(s, lst);
    r.typed     = 1'b1;
    r.typed_n   = n;
    r.typed_res = '{median: med, run_last: rl, record_end: re};
    return r;
  endfunction

  function automatic logic [11:0] rand_sample();
    unique case ($urandom_range(0, 7))
      0:       return 12'h000;
      1:       return 12'hFFF;
      2:       return 12'($urandom_range(0, 3));
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [15:0] rand_skip();
    unique case ($urandom_range(0, 9))
      0:       return 16'hFFFF;
      1, 2, 3: return 16'($urandom_range(1, 6));
      default: return 16'd0;
    endcase
  endfunction

  function automatic logic [15:0] rand_keep();
    unique case ($urandom_range(0, 9))
      0:       return 16'd0;
      1, 2, 3: return 16'($urandom_range(1, 8));
      default: return 16'hFFFF;
    endcase
  endfunction

  initial begin : stimulus
    stim_row_t   dir_rows [$];
    int unsigned rand_sent;
    int unsigned n_rec;
    int unsigned rec_len;
    int unsigned pick;
    bit          open_end;

    rst_ni       <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.sample <= '0;
    in_ch.last   <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part: single-sample records at the extremes give their own sample
    dir_rows.push_back(typed_row(12'hFFF, 1'b1, 1'b1, 12'hFFF, 1'b1, 1'b1));
    dir_rows.push_back(typed_row(12'h000, 1'b1, 1'b1, 12'h000, 1'b1, 1'b1));
    dir_rows.push_back(smp_row(12'hAAA, 1'b0));
    dir_rows.push_back(smp_row(12'h555, 1'b0));
    dir_rows.push_back(smp_row(12'h000, 1'b0));
    dir_rows.push_back(smp_row(12'hFFF, 1'b0));
    dir_rows.push_back(smp_row(12'h800, 1'b0));
    dir_rows.push_back(smp_row(12'h7FF, 1'b0));
    dir_rows.push_back(smp_row(12'h001, 1'b1));
    // window size zero behaves as one
    dir_rows.push_back(wr_row(REG_WINDOW_SIZE, 32'd0));
    dir_rows.push_back(typed_row(12'h5A5, 1'b1, 1'b1, 12'h5A5, 1'b1, 1'b1));
    // widest window, record shorter than the look-ahead
    dir_rows.push_back(wr_row(REG_WINDOW_SIZE, 32'd15));
    dir_rows.push_back(smp_row(12'h3C3, 1'b0));
    dir_rows.push_back(smp_row(12'hC3C, 1'b0));
    dir_rows.push_back(smp_row(12'hFFF, 1'b1));
    // even window with a narrow emission range
    dir_rows.push_back(wr_row(REG_WINDOW_SIZE, 32'd4));
    dir_rows.push_back(wr_row(REG_SKIP_FRONT, 32'd2));
    dir_rows.push_back(wr_row(REG_KEEP_COUNT, 32'd3));
    dir_rows.push_back(smp_row(12'd10, 1'b0));
    dir_rows.push_back(smp_row(12'd40, 1'b0));
    dir_rows.push_back(smp_row(12'd20, 1'b0));
    dir_rows.push_back(smp_row(12'd30, 1'b0));
    dir_rows.push_back(smp_row(12'd50, 1'b0));
    dir_rows.push_back(smp_row(12'd60, 1'b1));
    // keep count zero and skip at its top emit nothing
    dir_rows.push_back(wr_row(REG_KEEP_COUNT, 32'd0));
    dir_rows.push_back(typed_row(12'h111, 1'b1, 1'b0, 12'h000, 1'b0, 1'b0));
    dir_rows.push_back(wr_row(REG_KEEP_COUNT, 32'hFFFF));
    dir_rows.push_back(wr_row(REG_SKIP_FRONT, 32'hFFFF));
    dir_rows.push_back(typed_row(12'h222, 1'b1, 1'b0, 12'h000, 1'b0, 1'b0));
    // window size changed in the middle of a record
    dir_rows.push_back(wr_row(REG_SKIP_FRONT, 32'd0));
    dir_rows.push_back(wr_row(REG_WINDOW_SIZE, 32'd6));
    dir_rows.push_back(smp_row(12'd100, 1'b0));
    dir_rows.push_back(smp_row(12'd7, 1'b0));
    dir_rows.push_back(wr_row(REG_WINDOW_SIZE, 32'd3));
    dir_rows.push_back(smp_row(12'd900, 1'b0));
    dir_rows.push_back(smp_row(12'd5, 1'b1));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
      end else begin
        send_sample(dir_rows[i].sample, dir_rows[i].last, dir_rows[i].typed,
                    dir_rows[i].typed_n, dir_rows[i].typed_res);
      end
    end

    // random phases of records under random settings
    rand_sent = 0;
    while (rand_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 5);
      write_reg(REG_WINDOW_SIZE, (pick == 0) ? 32'd0 :
                                 (pick == 1) ? 32'd15 : 32'($urandom_range(1, 15)));
      write_reg(REG_SKIP_FRONT, {16'd0, rand_skip()});
      write_reg(REG_KEEP_COUNT, {16'd0, rand_keep()});
      src_burst = ($urandom_range(0, 3) == 0);
      snk_burst = ($urandom_range(0, 3) == 0);
      n_rec = $urandom_range(1, 3);
      for (int unsigned r = 0; r < n_rec; r++) begin
        rec_len  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 20);
        // now and then a record runs on into the next settings
        open_end = (r == n_rec - 1) && ($urandom_range(0, 5) == 0);
        for (int unsigned j = 0; j < rec_len; j++) begin
          send_sample(rand_sample(), (j == rec_len - 1) && !open_end, 1'b0, 1'b0, '0);
          rand_sent++;
        end
      end
    end
    src_burst = 1'b0;
    send_sample(rand_sample(), 1'b1, 1'b0, 1'b0, '0);

    wait_settled();
    if (errors == 0) begin
      $display("sliding_median_filter_core verification clean");
    end else begin
      $display("sliding_median_filter_core verification failed");
    end
    $finish;
  end

endmodule
